>>> sv/cme_pkg.sv
// ----------------------------------------------------------------------------
// Covariance matrix engine package
// Sizes, field widths and register indexes shared by the engine.
// ----------------------------------------------------------------------------
package cme_pkg;

    localparam int MAX_ASSETS  = 8;
    localparam int MAX_SAMPLES = 256;

    localparam int AIDX_W = $clog2(MAX_ASSETS);
    localparam int SIDX_W = $clog2(MAX_SAMPLES);
    localparam int ADDR_W = AIDX_W + SIDX_W;

    localparam int RET_W   = 27;
    localparam int DEV_W   = 28;
    localparam int PROD_W  = 56;
    localparam int ACC_W   = 63;
    localparam int SUM_W   = RET_W + SIDX_W;
    localparam int COV_W   = 56;
    localparam int ACNT_W  = 4;
    localparam int SCNT_W  = 9;
    localparam int CIDX_W  = 4;
    localparam int CDATA_W = 9;
    localparam int DCNT_W  = 6;

    typedef enum logic [CIDX_W-1:0] {
        CFG_ASSET_COUNT  = 4'd0,
        CFG_SAMPLE_COUNT = 4'd1
    } cfg_index_t;

endpackage

>>> sv/covariance_matrix_engine.sv
// After the last return of a data set the engine computes the means and the matrix (A assets,
// S samples), then sends the matrix entries one at a time, subject to output stalls.
// Throughput: one return per cycle while loading; a single shared read port pair,
// multiplier and one-bit-per-cycle divider (63 steps) set the computation time.
// Reset: asset count 8, sample count 256, positions zero; no memory clearing pass.
// ----------------------------------------------------------------------------
// Covariance matrix engine
// Stores return samples, then computes asset means and the population
// covariance matrix with one shared multiply-accumulate and divide unit.
// ----------------------------------------------------------------------------
module covariance_matrix_engine
    import cme_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CIDX_W-1:0]          cfg_index,
    input  logic [CDATA_W-1:0]         cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [RET_W-1:0]    s_return_value,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [COV_W-1:0]    m_cov_value,
    output logic [AIDX_W-1:0]          m_row_index,
    output logic [AIDX_W-1:0]          m_col_index,
    output logic                       m_last
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MEAN,
        S_DIV,
        S_STORE,
        S_MR,
        S_MC,
        S_MCAP,
        S_COV,
        S_ORD,
        S_OLOAD,
        S_OSEND
    } state_t;

    state_t state_reg;

    logic [ACNT_W-1:0]        asset_cnt_reg;
    logic [SCNT_W-1:0]        sample_cnt_reg;
    logic [AIDX_W-1:0]        apos_reg;
    logic [SIDX_W-1:0]        spos_reg;
    logic                     cov_phase_reg;
    logic [AIDX_W-1:0]        row_reg;
    logic [AIDX_W-1:0]        col_reg;
    logic [SCNT_W-1:0]        k_reg;
    logic                     p1_reg;
    logic                     p2_reg;
    logic                     p3_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [RET_W-1:0]  mean_r_reg;
    logic signed [RET_W-1:0]  mean_c_reg;
    logic signed [DEV_W-1:0]  dev_r_reg;
    logic signed [DEV_W-1:0]  dev_c_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [ACC_W-1:0]         dvd_reg;
    logic [SCNT_W-1:0]        rem_reg;
    logic [DCNT_W-1:0]        div_cnt_reg;
    logic                     div_neg_reg;

    // Memories and their registered read data.
    logic [RET_W-1:0] sample_store [MAX_ASSETS*MAX_SAMPLES];
    logic [RET_W-1:0] mean_mem [MAX_ASSETS];
    logic [COV_W-1:0] cov_mem [MAX_ASSETS*MAX_ASSETS];
    logic signed [RET_W-1:0] rd_a_reg;
    logic signed [RET_W-1:0] rd_b_reg;
    logic signed [RET_W-1:0] mean_rd_reg;
    logic [COV_W-1:0]        cov_rd_reg;

    logic [ACNT_W-1:0]       na_eff;
    logic [SCNT_W-1:0]       ns_eff;
    logic [AIDX_W-1:0]       na_m1;
    logic                    in_accept;
    logic                    issuing;
    logic [ADDR_W-1:0]       wr_addr;
    logic [ADDR_W-1:0]       rd_addr_a;
    logic [ADDR_W-1:0]       rd_addr_b;
    logic [AIDX_W-1:0]       mean_raddr;
    logic [AIDX_W-1:0]       out_lo;
    logic [AIDX_W-1:0]       out_hi;
    logic [2*AIDX_W-1:0]     cov_raddr;
    logic signed [63:0]      div_src;
    logic [63:0]             div_mag;
    logic [SCNT_W:0]         trial;
    logic                    trial_ge;
    logic [SCNT_W:0]         trial_sub;
    logic signed [63:0]      quot;
    logic signed [63:0]      acc_sum;
    logic signed [ACC_W-1:0] acc_sat;
    logic                    set_done;

    always_comb begin
        if (asset_cnt_reg == '0) begin
            na_eff = ACNT_W'(1);
        end else if (asset_cnt_reg > ACNT_W'(MAX_ASSETS)) begin
            na_eff = ACNT_W'(MAX_ASSETS);
        end else begin
            na_eff = asset_cnt_reg;
        end
        if (sample_cnt_reg == '0) begin
            ns_eff = SCNT_W'(1);
        end else if (sample_cnt_reg > SCNT_W'(MAX_SAMPLES)) begin
            ns_eff = SCNT_W'(MAX_SAMPLES);
        end else begin
            ns_eff = sample_cnt_reg;
        end
    end

    assign na_m1     = AIDX_W'(na_eff - ACNT_W'(1));
    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign in_accept = s_valid && s_ready;
    assign issuing   = (k_reg < ns_eff);
    assign set_done  = (apos_reg == na_m1) &&
                       ({1'b0, spos_reg} == SCNT_W'(ns_eff - SCNT_W'(1)));

    assign wr_addr    = {spos_reg, apos_reg};
    assign rd_addr_a  = {k_reg[SIDX_W-1:0], row_reg};
    assign rd_addr_b  = {k_reg[SIDX_W-1:0], col_reg};
    assign mean_raddr = (state_reg == S_MR) ? row_reg : col_reg;

    // Only the upper triangle is stored; lower entries read their mirror.
    assign out_lo    = (col_reg < row_reg) ? col_reg : row_reg;
    assign out_hi    = (col_reg < row_reg) ? row_reg : col_reg;
    assign cov_raddr = {out_lo, out_hi};

    // Divider operands: magnitude of the sum, sign restored after the quotient.
    assign div_src  = cov_phase_reg ? 64'(acc_reg) : 64'(sum_reg);
    assign div_mag  = div_src[63] ? 64'(-div_src) : 64'(div_src);
    assign trial    = {rem_reg, dvd_reg[ACC_W-1]};
    assign trial_ge = (trial >= {1'b0, ns_eff});
    assign trial_sub = trial - {1'b0, ns_eff};
    assign quot     = div_neg_reg ? -$signed({1'b0, dvd_reg}) : $signed({1'b0, dvd_reg});

    // Saturating accumulate into the 63-bit range.
    assign acc_sum = 64'(acc_reg) + 64'(prod_reg);
    always_comb begin
        if (acc_sum[63] != acc_sum[62]) begin
            acc_sat = acc_sum[63] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            acc_sat = acc_sum[ACC_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            sample_store[wr_addr] <= s_return_value;
        end
        rd_a_reg <= $signed(sample_store[rd_addr_a]);
        rd_b_reg <= $signed(sample_store[rd_addr_b]);
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_STORE && !cov_phase_reg) begin
            mean_mem[row_reg] <= quot[RET_W-1:0];
        end
        mean_rd_reg <= $signed(mean_mem[mean_raddr]);
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_STORE && cov_phase_reg) begin
            cov_mem[{row_reg, col_reg}] <= quot[COV_W-1:0];
        end
        cov_rd_reg <= cov_mem[cov_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            asset_cnt_reg  <= ACNT_W'(MAX_ASSETS);
            sample_cnt_reg <= SCNT_W'(MAX_SAMPLES);
            apos_reg       <= '0;
            spos_reg       <= '0;
            cov_phase_reg  <= 1'b0;
            row_reg        <= '0;
            col_reg        <= '0;
            k_reg          <= '0;
            p1_reg         <= 1'b0;
            p2_reg         <= 1'b0;
            p3_reg         <= 1'b0;
            div_cnt_reg    <= '0;
            m_valid        <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ASSET_COUNT: begin
                        asset_cnt_reg <= cfg_data[ACNT_W-1:0];
                        apos_reg      <= '0;
                        spos_reg      <= '0;
                    end
                    CFG_SAMPLE_COUNT: begin
                        sample_cnt_reg <= cfg_data;
                        apos_reg       <= '0;
                        spos_reg       <= '0;
                    end
                    default: begin
                    end
                endcase
            end

            case (state_reg)
                S_IDLE: begin
                    if (in_accept) begin
                        if (apos_reg == na_m1) begin
                            apos_reg <= '0;
                            if (set_done) begin
                                spos_reg      <= '0;
                                cov_phase_reg <= 1'b0;
                                row_reg       <= '0;
                                k_reg         <= '0;
                                p1_reg        <= 1'b0;
                                sum_reg       <= '0;
                                state_reg     <= S_MEAN;
                            end else begin
                                spos_reg <= spos_reg + SIDX_W'(1);
                            end
                        end else begin
                            apos_reg <= apos_reg + AIDX_W'(1);
                        end
                    end
                end

                S_MEAN: begin
                    if (issuing) begin
                        k_reg <= k_reg + SCNT_W'(1);
                    end
                    p1_reg <= issuing;
                    if (p1_reg) begin
                        sum_reg <= sum_reg + SUM_W'(rd_a_reg);
                    end
                    if (!issuing && !p1_reg) begin
                        div_neg_reg <= div_src[63];
                        dvd_reg     <= div_mag[ACC_W-1:0];
                        rem_reg     <= '0;
                        div_cnt_reg <= '0;
                        state_reg   <= S_DIV;
                    end
                end

                S_DIV: begin
                    rem_reg     <= trial_ge ? trial_sub[SCNT_W-1:0] : trial[SCNT_W-1:0];
                    dvd_reg     <= {dvd_reg[ACC_W-2:0], trial_ge};
                    div_cnt_reg <= div_cnt_reg + DCNT_W'(1);
                    if (div_cnt_reg == DCNT_W'(ACC_W - 1)) begin
                        state_reg <= S_STORE;
                    end
                end

                S_STORE: begin
                    if (!cov_phase_reg) begin
                        if (row_reg == na_m1) begin
                            cov_phase_reg <= 1'b1;
                            row_reg       <= '0;
                            col_reg       <= '0;
                            state_reg     <= S_MR;
                        end else begin
                            row_reg   <= row_reg + AIDX_W'(1);
                            k_reg     <= '0;
                            p1_reg    <= 1'b0;
                            sum_reg   <= '0;
                            state_reg <= S_MEAN;
                        end
                    end else if (col_reg == na_m1) begin
                        if (row_reg == na_m1) begin
                            row_reg   <= '0;
                            col_reg   <= '0;
                            state_reg <= S_ORD;
                        end else begin
                            row_reg   <= row_reg + AIDX_W'(1);
                            col_reg   <= row_reg + AIDX_W'(1);
                            state_reg <= S_MR;
                        end
                    end else begin
                        col_reg   <= col_reg + AIDX_W'(1);
                        state_reg <= S_MR;
                    end
                end

                S_MR: begin
                    state_reg <= S_MC;
                end

                S_MC: begin
                    mean_r_reg <= mean_rd_reg;
                    state_reg  <= S_MCAP;
                end

                S_MCAP: begin
                    mean_c_reg <= mean_rd_reg;
                    k_reg      <= '0;
                    acc_reg    <= '0;
                    p1_reg     <= 1'b0;
                    p2_reg     <= 1'b0;
                    p3_reg     <= 1'b0;
                    state_reg  <= S_COV;
                end

                S_COV: begin
                    // Read, deviation, product and accumulate form a four-step pipe.
                    if (issuing) begin
                        k_reg <= k_reg + SCNT_W'(1);
                    end
                    p1_reg <= issuing;
                    p2_reg <= p1_reg;
                    p3_reg <= p2_reg;
                    if (p1_reg) begin
                        dev_r_reg <= DEV_W'(rd_a_reg) - DEV_W'(mean_r_reg);
                        dev_c_reg <= DEV_W'(rd_b_reg) - DEV_W'(mean_c_reg);
                    end
                    if (p2_reg) begin
                        prod_reg <= dev_r_reg * dev_c_reg;
                    end
                    if (p3_reg) begin
                        acc_reg <= acc_sat;
                    end
                    if (!issuing && !p1_reg && !p2_reg && !p3_reg) begin
                        div_neg_reg <= div_src[63];
                        dvd_reg     <= div_mag[ACC_W-1:0];
                        rem_reg     <= '0;
                        div_cnt_reg <= '0;
                        state_reg   <= S_DIV;
                    end
                end

                S_ORD: begin
                    state_reg <= S_OLOAD;
                end

                S_OLOAD: begin
                    m_cov_value <= $signed(cov_rd_reg);
                    m_row_index <= row_reg;
                    m_col_index <= col_reg;
                    m_last      <= (row_reg == na_m1) && (col_reg == na_m1);
                    m_valid     <= 1'b1;
                    state_reg   <= S_OSEND;
                end

                S_OSEND: begin
                    if (m_ready) begin
                        m_valid <= 1'b0;
                        if (col_reg == na_m1) begin
                            col_reg <= '0;
                            if (row_reg == na_m1) begin
                                row_reg   <= '0;
                                state_reg <= S_IDLE;
                            end else begin
                                row_reg   <= row_reg + AIDX_W'(1);
                                state_reg <= S_ORD;
                            end
                        end else begin
                            col_reg   <= col_reg + AIDX_W'(1);
                            state_reg <= S_ORD;
                        end
                    end
                end

                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// Covariance matrix engine testbench
// Streams return samples through the engine under random idling on both
// channels and reprograms the asset and sample counts between data sets.
// Expected matrices come from a local model of the population covariance.
// Every entry is checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
    import cme_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 6;
    localparam int RANDOM_ITEMS  = 80;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES  = 64;
    localparam int QUIET_LIMIT   = 40000;

    localparam logic [CIDX_W-1:0] CFG_UNUSED_TOP = '1;

    localparam logic signed [RET_W-1:0] RET_MAX = {1'b0, {(RET_W-1){1'b1}}};
    localparam logic signed [RET_W-1:0] RET_MIN = {1'b1, {(RET_W-1){1'b0}}};
    localparam longint ACC_HI = (longint'(1) <<< (ACC_W - 1)) - 1;
    localparam longint ACC_LO = -ACC_HI - 1;

    typedef enum int {FILL_RANDOM, FILL_EXTREME, FILL_SMALL, FILL_CLUSTER} fill_t;

    typedef struct {
        logic signed [COV_W-1:0] cov;
        logic [AIDX_W-1:0]       row;
        logic [AIDX_W-1:0]       col;
        logic                    last;
    } cov_entry_t;

    logic                     aclk           = 1'b0;
    logic                     aresetn        = 1'b0;
    logic                     cfg_valid      = 1'b0;
    logic                     cfg_ready;
    logic [CIDX_W-1:0]        cfg_index      = '0;
    logic [CDATA_W-1:0]       cfg_data       = '0;
    logic                     s_valid        = 1'b0;
    logic                     s_ready;
    logic signed [RET_W-1:0]  s_return_value = '0;
    logic                     m_valid;
    logic                     m_ready        = 1'b0;
    logic signed [COV_W-1:0]  m_cov_value;
    logic [AIDX_W-1:0]        m_row_index;
    logic [AIDX_W-1:0]        m_col_index;
    logic                     m_last;

    // Local copy of the engine state.
    logic [ACNT_W-1:0]        asset_count_reg  = ACNT_W'(MAX_ASSETS);
    logic [SCNT_W-1:0]        sample_count_reg = SCNT_W'(MAX_SAMPLES);
    int                       asset_pos        = 0;
    int                       sample_pos       = 0;
    logic signed [RET_W-1:0]  return_mem [MAX_ASSETS*MAX_SAMPLES];

    logic signed [RET_W-1:0]  pending_returns[$];
    cov_entry_t               cov_expected[$];

    logic ret_taken    = 1'b0;
    logic steady_flow  = 1'b0;
    int   ret_gap      = 0;
    int   stall_left   = 0;
    int   quiet_cycles = 0;
    int   mismatches   = 0;

    covariance_matrix_engine u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_return_value (s_return_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_cov_value    (m_cov_value),
        .m_row_index    (m_row_index),
        .m_col_index    (m_col_index),
        .m_last         (m_last)
    );

    always #HALF_PERIOD aclk = ~aclk;

    function automatic int clamp_count(int value, int limit);
        if (value < 1) return 1;
        if (value > limit) return limit;
        return value;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [RET_W-1:0] make_return(fill_t fill,
                                                             logic signed [RET_W-1:0] base);
        case (fill)
            FILL_RANDOM:  return RET_W'($urandom());
            FILL_EXTREME: return $urandom_range(0, 1) ? RET_MAX : RET_MIN;
            FILL_SMALL:   return RET_W'(int'($urandom_range(0, 4000)) - 2000);
            default:      return base + RET_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic apply_register(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] value);
        case (idx)
            CFG_ASSET_COUNT: begin
                asset_count_reg = value[ACNT_W-1:0];
                asset_pos = 0;
                sample_pos = 0;
            end
            CFG_SAMPLE_COUNT: begin
                sample_count_reg = value[SCNT_W-1:0];
                asset_pos = 0;
                sample_pos = 0;
            end
            default: ;
        endcase
    endtask

    // Stores one return; on the final return of a data set computes the means
    // and the full matrix from the upper triangle.
    task automatic absorb_return(logic signed [RET_W-1:0] value);
        int na, ns, r0, c0;
        longint sum, acc, dr, dc, quotient;
        logic signed [RET_W-1:0] means [MAX_ASSETS];
        cov_entry_t e;
        na = clamp_count(int'(asset_count_reg), MAX_ASSETS);
        ns = clamp_count(int'(sample_count_reg), MAX_SAMPLES);
        if (asset_pos >= na) asset_pos = 0;
        if (sample_pos >= ns) sample_pos = 0;
        return_mem[sample_pos*MAX_ASSETS + asset_pos] = value;
        asset_pos++;
        if (asset_pos < na) return;
        asset_pos = 0;
        sample_pos++;
        if (sample_pos < ns) return;
        sample_pos = 0;

        for (int j = 0; j < na; j++) begin
            sum = 0;
            for (int k = 0; k < ns; k++)
                sum += longint'(return_mem[k*MAX_ASSETS + j]);
            means[j] = RET_W'(sum / ns);
        end

        for (int i = 0; i < na; i++) begin
            for (int j = 0; j < na; j++) begin
                r0 = (j < i) ? j : i;
                c0 = (j < i) ? i : j;
                acc = 0;
                for (int k = 0; k < ns; k++) begin
                    dr = longint'(return_mem[k*MAX_ASSETS + r0]) - longint'(means[r0]);
                    dc = longint'(return_mem[k*MAX_ASSETS + c0]) - longint'(means[c0]);
                    acc = acc + dr * dc;
                    if (acc > ACC_HI) acc = ACC_HI;
                    if (acc < ACC_LO) acc = ACC_LO;
                end
                quotient = acc / ns;
                e.cov  = COV_W'(quotient);
                e.row  = AIDX_W'(i);
                e.col  = AIDX_W'(j);
                e.last = (i == na - 1) && (j == na - 1);
                cov_expected.push_back(e);
            end
        end
    endtask

    // Return channel driver.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || ret_taken) begin
            if (ret_gap > 0) begin
                ret_gap <= ret_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_returns.size() != 0) begin
                s_return_value <= pending_returns.pop_front();
                s_valid <= 1'b1;
                ret_gap <= steady_flow ? 0 : pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result channel back-pressure.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (!steady_flow && $urandom_range(0, 3) == 0) begin
            stall_left <= pick_gap();
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : monitor
        cov_entry_t want;
        if (!aresetn) begin
            ret_taken <= 1'b0;
        end else begin
            ret_taken <= s_valid && s_ready;
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index, cfg_data);
            if (s_valid && s_ready)
                absorb_return(s_return_value);
            if (m_valid && m_ready) begin
                if (cov_expected.size() == 0) begin
                    $error("unexpected covariance entry: row %0d col %0d value %0d",
                           m_row_index, m_col_index, m_cov_value);
                    mismatches++;
                end else begin
                    want = cov_expected.pop_front();
                    if (m_cov_value !== want.cov) begin
                        $error("cov_value: expected %0d, actual %0d", want.cov, m_cov_value);
                        mismatches++;
                    end
                    if (m_row_index !== want.row) begin
                        $error("row_index: expected %0d, actual %0d", want.row, m_row_index);
                        mismatches++;
                    end
                    if (m_col_index !== want.col) begin
                        $error("col_index: expected %0d, actual %0d", want.col, m_col_index);
                        mismatches++;
                    end
                    if (m_last !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, m_last);
                        mismatches++;
                    end
                end
            end
            if ((cfg_valid && cfg_ready) || (s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic write_register(logic [CIDX_W-1:0] idx, int value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CDATA_W'(value);
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_returns(int count, fill_t fill);
        logic signed [RET_W-1:0] base;
        base = make_return(FILL_RANDOM, '0);
        for (int n = 0; n < count; n++)
            pending_returns.push_back(make_return(fill, base));
    endtask

    // Waits until every return is taken and every entry has come back.
    task automatic settle();
        while (pending_returns.size() != 0 || s_valid || cov_expected.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin : stimulus
        int assets_w, samples_w, eff_a, eff_s, sets, r, random_items;
        random_items = 0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Zero counts act as one asset and one sample: a zero matrix per return.
        write_register(CFG_ASSET_COUNT, 0);
        write_register(CFG_SAMPLE_COUNT, 0);
        pending_returns.push_back(RET_MAX);
        pending_returns.push_back(RET_MIN);
        pending_returns.push_back('0);
        settle();

        // An unknown register index must not restart a partly loaded set.
        write_register(CFG_ASSET_COUNT, 2);
        write_register(CFG_SAMPLE_COUNT, 2);
        pending_returns.push_back(RET_MAX);
        pending_returns.push_back(RET_MIN);
        pending_returns.push_back(RET_MIN);
        settle();
        write_register(CFG_UNUSED_TOP, (1 << CDATA_W) - 1);
        pending_returns.push_back(RET_MAX);
        settle();

        // A real register write abandons a partly loaded set.
        pending_returns.push_back(RET_MIN);
        pending_returns.push_back('0);
        settle();
        write_register(CFG_SAMPLE_COUNT, 2);

        // Oversized asset count is limited to the maximum; full-scale swings.
        write_register(CFG_ASSET_COUNT, (1 << ACNT_W) - 1);
        for (int s = 0; s < 2; s++)
            for (int a = 0; a < MAX_ASSETS; a++)
                pending_returns.push_back(((a + s) % 2 == 0) ? RET_MAX : RET_MIN);
        settle();

        while (random_items < RANDOM_ITEMS) begin
            steady_flow = ($urandom_range(0, 3) == 0);
            assets_w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, (1 << ACNT_W) - 1)
                                                   : $urandom_range(1, MAX_ASSETS);
            r = $urandom_range(0, 99);
            if (r < 70)      samples_w = $urandom_range(1, 4);
            else if (r < 92) samples_w = $urandom_range(5, 12);
            else if (r < 97) samples_w = $urandom_range(13, 40);
            else             samples_w = 0;
            eff_a = clamp_count(assets_w, MAX_ASSETS);
            eff_s = clamp_count(samples_w, MAX_SAMPLES);

            if ($urandom_range(0, 7) == 0)
                write_register(CIDX_W'($urandom_range(CFG_SAMPLE_COUNT + 1, CFG_UNUSED_TOP)),
                               $urandom_range(0, (1 << CDATA_W) - 1));
            if ($urandom_range(0, 1)) begin
                write_register(CFG_ASSET_COUNT, assets_w);
                write_register(CFG_SAMPLE_COUNT, samples_w);
            end else begin
                write_register(CFG_SAMPLE_COUNT, samples_w);
                write_register(CFG_ASSET_COUNT, assets_w);
            end

            sets = $urandom_range(1, 3);
            for (int n = 0; n < sets; n++) begin
                if (eff_a * eff_s > 1 && $urandom_range(0, 7) == 0) begin
                    load_returns($urandom_range(1, eff_a * eff_s - 1),
                                 fill_t'($urandom_range(FILL_RANDOM, FILL_CLUSTER)));
                    settle();
                    write_register(CFG_SAMPLE_COUNT, samples_w);
                end
                load_returns(eff_a * eff_s, fill_t'($urandom_range(FILL_RANDOM, FILL_CLUSTER)));
                random_items += eff_a * eff_s;
            end
            settle();
        end

        // Longest sample series: one asset, sample count above the maximum.
        steady_flow = 1'b0;
        write_register(CFG_ASSET_COUNT, 1);
        write_register(CFG_SAMPLE_COUNT, (1 << CDATA_W) - 1);
        load_returns(MAX_SAMPLES, FILL_RANDOM);
        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> filelist.f
sv/cme_pkg.sv
sv/covariance_matrix_engine.sv
tb/tb_top.sv
